// File: rtl/e2q_pkg.sv
// Shared constants, fixed-point helpers and the arctangent table for the
// roll-pitch-yaw to quaternion pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

    // Number of entries in the arctangent table.
    localparam int TABLE_LEN = 24;

    // Q2.30 constants.
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

    // Output limits in Q1.14.
    localparam logic signed [33:0] OUT_MAX = 34'sd16384;
    localparam logic signed [33:0] OUT_MIN = -34'sd16384;

    // Q2.30 value type used through the datapath.
    typedef logic signed [31:0] t_q30;

    // atan(2^-i) in Q2.30, truncated.
    function automatic t_q30 atan_q30(input int idx);
        case (idx)
            0:       return 32'sd843314856;
            1:       return 32'sd497837829;
            2:       return 32'sd263043836;
            3:       return 32'sd133525158;
            4:       return 32'sd67021686;
            5:       return 32'sd33543515;
            6:       return 32'sd16775850;
            7:       return 32'sd8388437;
            8:       return 32'sd4194282;
            9:       return 32'sd2097149;
            10:      return 32'sd1048575;
            11:      return 32'sd524287;
            12:      return 32'sd262143;
            13:      return 32'sd131071;
            14:      return 32'sd65535;
            15:      return 32'sd32767;
            16:      return 32'sd16383;
            17:      return 32'sd8191;
            18:      return 32'sd4095;
            19:      return 32'sd2047;
            20:      return 32'sd1023;
            21:      return 32'sd511;
            22:      return 32'sd255;
            23:      return 32'sd127;
            default: return 32'sd0;
        endcase
    endfunction

    // Q2.30 product, floored back to Q2.30.
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

    // Round to nearest (ties up) into Q1.14 and saturate.
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > OUT_MAX) begin
            return 16'sd16384;
        end else if (t < OUT_MIN) begin
            return -16'sd16384;
        end
        return t[15:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/e2q_in_if.sv
// Input channel: one word holds roll, pitch and yaw angles.
// Standalone; width follows ANGLE_WIDTH.
`timescale 1ns / 1ps
`default_nettype none
interface e2q_in_if #(parameter int ANGLE_WIDTH = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, output ready);
endinterface
`default_nettype wire

// File: rtl/e2q_out_if.sv
// Output channel: one word holds the four quaternion components in Q1.14.
// Standalone.
`timescale 1ns / 1ps
`default_nettype none
interface e2q_out_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface
`default_nettype wire

// File: rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC for one angle: halving, quadrant fold,
// one register stage per iteration and a sign-restore stage. Uses e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic #(
    parameter int ITERATIONS  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle,
    output e2q_pkg::t_q30                      o_cos,
    output e2q_pkg::t_q30                      o_sin
);
    import e2q_pkg::*;

    localparam int STEPS = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    t_q30 r_x    [0:STEPS];
    t_q30 r_y    [0:STEPS];
    t_q30 r_z    [0:STEPS];
    logic r_flip [0:STEPS];

    logic signed [33:0] n_half;

    // Halve the angle into Q2.30 radians.
    always_comb begin
        n_half = 34'(i_angle) <<< (32 - ANGLE_WIDTH);
    end

    // Fold into [-pi/2, pi/2]; the fold negates cosine and sine.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            if (n_half > HALF_PI_Q30) begin
                r_z[0]    <= 32'(n_half - PI_Q30);
                r_flip[0] <= 1'b1;
            end else if (n_half < -HALF_PI_Q30) begin
                r_z[0]    <= 32'(n_half + PI_Q30);
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= n_half[31:0];
                r_flip[0] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[g+1] <= r_flip[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
            end
        end
    end

    // Restore the sign removed by the quadrant fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_flip[STEPS] ? -r_x[STEPS] : r_x[STEPS];
            o_sin <= r_flip[STEPS] ? -r_y[STEPS] : r_y[STEPS];
        end
    end

endmodule
`default_nettype wire

// File: rtl/e2q_combine.sv
// Quaternion combine: two product stages and a sum, round and saturate stage.
// Uses e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  e2q_pkg::t_q30      i_cr,
    input  e2q_pkg::t_q30      i_sr,
    input  e2q_pkg::t_q30      i_cp,
    input  e2q_pkg::t_q30      i_sp,
    input  e2q_pkg::t_q30      i_cy,
    input  e2q_pkg::t_q30      i_sy,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z,
    output logic signed [15:0] o_w
);
    import e2q_pkg::*;

    t_q30 r_crcp, r_srsp, r_srcp, r_crsp, r_cy, r_sy;
    t_q30 r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;

    // Roll-pitch products; yaw terms wait one stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crcp <= mul_q30(i_cr, i_cp);
            r_srsp <= mul_q30(i_sr, i_sp);
            r_srcp <= mul_q30(i_sr, i_cp);
            r_crsp <= mul_q30(i_cr, i_sp);
            r_cy   <= i_cy;
            r_sy   <= i_sy;
        end
    end

    // Products with the yaw terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= mul_q30(r_srcp, r_cy);
            r_p1 <= mul_q30(r_crsp, r_sy);
            r_p2 <= mul_q30(r_crsp, r_cy);
            r_p3 <= mul_q30(r_srcp, r_sy);
            r_p4 <= mul_q30(r_crcp, r_sy);
            r_p5 <= mul_q30(r_srsp, r_cy);
            r_p6 <= mul_q30(r_crcp, r_cy);
            r_p7 <= mul_q30(r_srsp, r_sy);
        end
    end

    // Exact sums, then rounding into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= to_q14(34'(r_p0) - 34'(r_p1));
            o_y <= to_q14(34'(r_p2) + 34'(r_p3));
            o_z <= to_q14(34'(r_p4) - 34'(r_p5));
            o_w <= to_q14(34'(r_p6) + 34'(r_p7));
        end
    end

endmodule
`default_nettype wire

// File: rtl/euler_to_quaternion_core.sv
// Top level of the roll-pitch-yaw to quaternion pipeline.
// Depends on e2q_pkg, e2q_in_if, e2q_out_if, e2q_cordic and e2q_combine.
//
// Usage:
//   i_in carries one word of roll, pitch and yaw angles (signed Q3.x radians,
//   ANGLE_WIDTH bits). o_out carries one word of quat_x, quat_y, quat_z and
//   quat_w in signed Q1.14, rounded and saturated to plus or minus one.
//   A word is moved when valid and ready are both high at a rising edge.
// Pipeline stages and throughput:
//   Stages in order: fold stage, one stage per CORDIC iteration,
//   sign stage, two multiplier stages and the output stage.
//   One word is accepted every cycle unless the output stalls; the three CORDIC
//   lanes and twelve multipliers all run in parallel, so depth sets only latency.
// Reset:
//   Synchronous, active low. All valid bits clear; data registers are not reset.
// Stall:
//   When the output word is held, the whole pipeline freezes and i_in.ready
//   drops; nothing is lost or repeated. Bubbles advance whenever the output
//   register is empty or taken.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_core #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_WIDTH       = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    e2q_in_if.sink     i_in,
    e2q_out_if.source  o_out
);
    import e2q_pkg::*;

    localparam int STEPS   = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS
                                                             : TABLE_LEN;
    localparam int LATENCY = STEPS + 5;

    logic               en;
    logic [LATENCY-1:0] r_valid;
    t_q30               cr, sr, cp, sp, cy, sy;

    // The pipeline moves unless a finished word is waiting.
    assign en         = !r_valid[LATENCY-1] || o_out.ready;
    assign i_in.ready = en;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LATENCY-2:0], i_in.valid};
        end
    end

    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.roll_angle), .o_cos(cr), .o_sin(sr)
    );
    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.pitch_angle), .o_cos(cp), .o_sin(sp)
    );
    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.yaw_angle), .o_cos(cy), .o_sin(sy)
    );

    e2q_combine u_combine (
        .i_clk(i_clk), .i_en(en),
        .i_cr(cr), .i_sr(sr), .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy),
        .o_x(o_out.quat_x), .o_y(o_out.quat_y), .o_z(o_out.quat_z), .o_w(o_out.quat_w)
    );

    assign o_out.valid = r_valid[LATENCY-1];

    // Pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_valid == '0)
        else $error("pipeline not empty after reset");

    // A stall freezes every valid bit.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_valid))
        else $error("valid bits moved during stall");

    // Delivered x and y components stay within plus or minus one.
    a_range_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_x <= 16'sd16384 && o_out.quat_x >= -16'sd16384
                      && o_out.quat_y <= 16'sd16384 && o_out.quat_y >= -16'sd16384))
        else $error("x or y component out of range");

    // Delivered z and w components stay within plus or minus one.
    a_range_zw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_z <= 16'sd16384 && o_out.quat_z >= -16'sd16384
                      && o_out.quat_w <= 16'sd16384 && o_out.quat_w >= -16'sd16384))
        else $error("z or w component out of range");

endmodule
`default_nettype wire
